// ===== rtl/kps_pkg.sv =====
// Shared constants, types and key table of the matrix keypad scanner.
`timescale 1ns / 1ps
`default_nettype none

package kps_pkg;

  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 4;
  localparam int COUNTER_BITS_DEF = 16;

  localparam int ROW_W = 2;
  localparam int COL_W = 2;
  localparam int RISE_W = 4;
  localparam int DRIVE_W = 4;
  localparam int CHAR_W = 8;

  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DWELL    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b1;

  localparam logic [CFG_W-1:0] DWELL_RESET    = 16'd10;
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd100;

  typedef struct packed {
    logic             enabled;
    logic [COL_W-1:0] idx;
  } col_state_t;

  typedef struct packed {
    logic             found;
    logic [ROW_W-1:0] row;
  } row_hit_t;

  function automatic logic [CHAR_W-1:0] kps_key_char(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
    logic [CHAR_W-1:0] key;
    begin
      case ({row, col})
        4'h0: key = "1";
        4'h1: key = "2";
        4'h2: key = "3";
        4'h3: key = "A";
        4'h4: key = "4";
        4'h5: key = "5";
        4'h6: key = "6";
        4'h7: key = "B";
        4'h8: key = "7";
        4'h9: key = "8";
        4'hA: key = "9";
        4'hB: key = "C";
        4'hC: key = "E";
        4'hD: key = "0";
        4'hE: key = "F";
        4'hF: key = "D";
        default: key = '0;
      endcase
      return key;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kps_in_if.sv =====
// Input channel of the keypad scanner: one tick word with the row edges.
`timescale 1ns / 1ps
`default_nettype none

interface kps_in_if;
  import kps_pkg::*;

  logic              valid;
  logic              ready;
  logic [RISE_W-1:0] row_rise;

  modport source (output valid, output row_rise, input ready);
  modport sink (input valid, input row_rise, output ready);
endinterface

`default_nettype wire

// ===== rtl/kps_out_if.sv =====
// Output channel of the keypad scanner: column drive and key report word.
`timescale 1ns / 1ps
`default_nettype none

interface kps_out_if;
  import kps_pkg::*;

  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] column_drive;
  logic               key_valid;
  logic [ROW_W-1:0]   key_row;
  logic [COL_W-1:0]   key_col;
  logic [CHAR_W-1:0]  key_char;

  modport source (output valid, output column_drive, output key_valid, output key_row,
                  output key_col, output key_char, input ready);
  modport sink (input valid, input column_drive, input key_valid, input key_row,
                input key_col, input key_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/kps_column.sv =====
// Column sequencer: dwell counter and cyclic column index.
`timescale 1ns / 1ps
`default_nettype none

module kps_column #(
  parameter int COUNTER_BITS = kps_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire logic [COUNTER_BITS-1:0] dwell_i,
  output kps_pkg::col_state_t          col_o
);
  import kps_pkg::*;

  logic [COUNTER_BITS-1:0] count_q, count_d;
  logic [COL_W-1:0]        idx_q, idx_d;
  logic                    enabled_q, enabled_d;
  logic [COUNTER_BITS-1:0] dwell_eff;
  logic [COUNTER_BITS:0]   count_inc;
  logic                    wrap;

  // A dwell of zero behaves as one.
  assign dwell_eff = (dwell_i == '0) ? COUNTER_BITS'(1) : dwell_i;
  assign count_inc = {1'b0, count_q} + (COUNTER_BITS + 1)'(1);
  assign wrap      = count_inc >= {1'b0, dwell_eff};

  always_comb begin
    count_d   = count_inc[COUNTER_BITS-1:0];
    idx_d     = idx_q;
    enabled_d = enabled_q;
    if (wrap) begin
      count_d   = '0;
      idx_d     = (idx_q == COL_W'(NUM_COLS - 1)) ? '0 : idx_q + COL_W'(1);
      enabled_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      idx_q     <= COL_W'(NUM_COLS - 1);
      enabled_q <= 1'b0;
    end else if (step_i) begin
      count_q   <= count_d;
      idx_q     <= idx_d;
      enabled_q <= enabled_d;
    end
  end

  // Report the column state after this tick's advance.
  assign col_o.enabled = enabled_d;
  assign col_o.idx     = idx_d;

endmodule

`default_nettype wire

// ===== rtl/kps_holdoff.sv =====
// Per-row retriggering holdoff counters and highest-row edge selection.
`timescale 1ns / 1ps
`default_nettype none

module kps_holdoff #(
  parameter int COUNTER_BITS = kps_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [kps_pkg::NUM_ROWS-1:0]  rise_i,
  input  wire logic [COUNTER_BITS-1:0]       debounce_i,
  output kps_pkg::row_hit_t                  hit_o
);
  import kps_pkg::*;

  logic [COUNTER_BITS-1:0] holdoff_q [NUM_ROWS];
  logic [COUNTER_BITS-1:0] holdoff_d [NUM_ROWS];
  logic [COUNTER_BITS-1:0] dec       [NUM_ROWS];
  logic [NUM_ROWS-1:0]     hit;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      // Count down first, then check the edge against the drained counter.
      dec[r]       = (holdoff_q[r] != '0) ? holdoff_q[r] - COUNTER_BITS'(1) : holdoff_q[r];
      hit[r]       = rise_i[r] && (dec[r] == '0);
      holdoff_d[r] = rise_i[r] ? debounce_i : dec[r];
    end
  end

  always_comb begin
    hit_o.found = |hit;
    hit_o.row   = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (hit[r]) begin
        hit_o.row = ROW_W'(r);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        holdoff_q[r] <= '0;
      end
    end else if (step_i) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        holdoff_q[r] <= holdoff_d[r];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/matrix_keypad_scanner.sv =====
// Path: an accepted tick word goes through the input register and then the
// result register to out_o. Throughput: one tick word per cycle unless
// out_o stalls; the column sequencer and the row holdoff counters update
// in the single cycle a word moves from the input to the result register.
// Reset: asynchronous, active low; dwell 10, debounce 100, no column driven,
// column index at the last column, all holdoff counters zero.
`timescale 1ns / 1ps
`default_nettype none

module matrix_keypad_scanner #(
  parameter int COUNTER_BITS = kps_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [kps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [kps_pkg::CFG_W-1:0]      cfg_data_i,
  kps_in_if.sink                              in_i,
  kps_out_if.source                           out_o
);
  import kps_pkg::*;

  localparam int ExtW = CFG_W + COUNTER_BITS;

  logic [CFG_W-1:0]        dwell_cfg_q;
  logic [CFG_W-1:0]        debounce_cfg_q;
  logic [ExtW-1:0]         dwell_ext;
  logic [ExtW-1:0]         debounce_ext;
  logic [COUNTER_BITS-1:0] dwell_cut;
  logic [COUNTER_BITS-1:0] debounce_cut;

  logic              s1_valid_q;
  logic [RISE_W-1:0] rise_q;
  logic              advance;
  logic              step;
  col_state_t        col;
  row_hit_t          hit;

  logic               out_valid_q;
  logic [DRIVE_W-1:0] drive_q, drive_d;
  logic               key_valid_q;
  logic [ROW_W-1:0]   key_row_q, key_row_d;
  logic [COL_W-1:0]   key_col_q, key_col_d;
  logic [CHAR_W-1:0]  key_char_q, key_char_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_cfg_q    <= DWELL_RESET;
      debounce_cfg_q <= DEBOUNCE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DWELL:    dwell_cfg_q    <= cfg_data_i;
        CFG_DEBOUNCE: debounce_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Cut or extend the register values to the counter width.
  assign dwell_ext    = {{COUNTER_BITS{1'b0}}, dwell_cfg_q};
  assign debounce_ext = {{COUNTER_BITS{1'b0}}, debounce_cfg_q};
  assign dwell_cut    = dwell_ext[COUNTER_BITS-1:0];
  assign debounce_cut = debounce_ext[COUNTER_BITS-1:0];

  assign advance    = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      rise_q <= in_i.row_rise;
    end
  end

  kps_column #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_column (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .dwell_i(dwell_cut),
    .col_o  (col)
  );

  kps_holdoff #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_holdoff (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rise_i    (rise_q[NUM_ROWS-1:0]),
    .debounce_i(debounce_cut),
    .hit_o     (hit)
  );

  always_comb begin
    drive_d    = col.enabled ? (DRIVE_W'(1) << col.idx) : '0;
    key_row_d  = '0;
    key_col_d  = '0;
    key_char_d = '0;
    if (hit.found) begin
      key_row_d  = hit.row;
      key_col_d  = col.idx;
      key_char_d = kps_key_char(hit.row, col.idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Hold the result word until the sink takes it.
  always_ff @(posedge clk_i) begin
    if (step) begin
      drive_q     <= drive_d;
      key_valid_q <= hit.found;
      key_row_q   <= key_row_d;
      key_col_q   <= key_col_d;
      key_char_q  <= key_char_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.column_drive = drive_q;
  assign out_o.key_valid    = key_valid_q;
  assign out_o.key_row      = key_row_q;
  assign out_o.key_col      = key_col_q;
  assign out_o.key_char     = key_char_q;

endmodule

`default_nettype wire
